// File: hdl/eeb_pkg.sv
// Shared definitions for the extended Euclid block.
// Used by eeb_ctrl, eeb_dpath and extended_euclid_bezout_top; depends on nothing.
package eeb_pkg;

    localparam int WIDTH_DEF = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic capture;
    } eeb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic r1_zero;
    } eeb_sts_t;

endpackage

// File: hdl/eeb_ctrl.sv
// Controller state machine for the extended Euclid block.
// Depends on eeb_pkg for the command and status structs.
module eeb_ctrl
    import eeb_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output eeb_cmd_t cmd,
    input  eeb_sts_t sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam int CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (sts.r1_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_TEST;
            end
            S_DONE:
            begin
                // The result register is free, or is being emptied at this edge.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.capture    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || !out_stall))
        else $error("result captured over an untaken result");

    a_accept_test: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_TEST))
        else $error("accepted request did not start the remainder test");

    a_full_divide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> ($past(cnt_reg) == CNT_LAST))
        else $error("update reached before all quotient bits were formed");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall))
        else $error("result withdrawn while stalled");
`endif

endmodule

// File: hdl/eeb_dpath.sv
// Datapath for the extended Euclid block: remainders, coefficients,
// a restoring divider with shift-add coefficient products. Depends on eeb_pkg.
module eeb_dpath
    import eeb_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  eeb_cmd_t                cmd,
    output eeb_sts_t                sts,
    input  logic signed [WIDTH-1:0] first_operand,
    input  logic signed [WIDTH-1:0] second_operand,
    output logic        [WIDTH-1:0] divisor_value,
    output logic signed [WIDTH:0]   coef_first,
    output logic signed [WIDTH:0]   coef_second
);

    localparam int CW = WIDTH + 1;

    logic [WIDTH-1:0] r0_reg, r1_reg;
    logic [CW-1:0]    s0_reg, s1_reg, t0_reg, t1_reg;
    logic [WIDTH-1:0] rem_reg, qd_reg, dvs_reg;
    logic [CW-1:0]    acc_s_reg, acc_t_reg;
    logic [WIDTH-1:0] g_reg;
    logic [CW-1:0]    x_reg, y_reg;

    logic [WIDTH-1:0] r0_mag, r1_mag, r2;
    logic [WIDTH:0]   shifted, trial;
    logic             qbit, neg_q;
    logic [CW-1:0]    s2, t2;

    assign r0_mag = r0_reg[WIDTH-1] ? (~r0_reg + WIDTH'(1)) : r0_reg;
    assign r1_mag = r1_reg[WIDTH-1] ? (~r1_reg + WIDTH'(1)) : r1_reg;

    // One restoring step: bring down the next dividend bit and try the divisor.
    assign shifted = {rem_reg, qd_reg[WIDTH-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign qbit    = !trial[WIDTH];

    // Remainder takes the dividend's sign; the quotient's sign picks add or
    // subtract of the accumulated product. Coefficients work modulo 2^CW,
    // which is exact as every true value fits.
    assign neg_q = r0_reg[WIDTH-1] ^ r1_reg[WIDTH-1];
    assign r2    = r0_reg[WIDTH-1] ? (~rem_reg + WIDTH'(1)) : rem_reg;
    assign s2    = neg_q ? (s0_reg + acc_s_reg) : (s0_reg - acc_s_reg);
    assign t2    = neg_q ? (t0_reg + acc_t_reg) : (t0_reg - acc_t_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r0_reg <= first_operand;
            r1_reg <= second_operand;
            s0_reg <= CW'(1);
            s1_reg <= '0;
            t0_reg <= '0;
            t1_reg <= CW'(1);
        end
        else if (cmd.update)
        begin
            r0_reg <= r1_reg;
            r1_reg <= r2;
            s0_reg <= s1_reg;
            s1_reg <= s2;
            t0_reg <= t1_reg;
            t1_reg <= t2;
        end

        if (cmd.div_init)
        begin
            rem_reg   <= '0;
            qd_reg    <= r0_mag;
            dvs_reg   <= r1_mag;
            acc_s_reg <= '0;
            acc_t_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg   <= qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
            qd_reg    <= {qd_reg[WIDTH-2:0], qbit};
            acc_s_reg <= {acc_s_reg[CW-2:0], 1'b0} + (qbit ? s1_reg : '0);
            acc_t_reg <= {acc_t_reg[CW-2:0], 1'b0} + (qbit ? t1_reg : '0);
        end

        if (cmd.capture)
        begin
            g_reg <= r0_mag;
            x_reg <= r0_reg[WIDTH-1] ? (CW'(0) - s0_reg) : s0_reg;
            y_reg <= r0_reg[WIDTH-1] ? (CW'(0) - t0_reg) : t0_reg;
        end
    end

    assign sts.r1_zero  = (r1_reg == '0);
    assign divisor_value = g_reg;
    assign coef_first    = x_reg;
    assign coef_second   = y_reg;

`ifndef ASSERT_OFF
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

    a_nonzero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_init |-> !sts.r1_zero)
        else $error("division started with a zero divisor");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_init, cmd.div_step, cmd.update, cmd.capture}))
        else $error("conflicting datapath commands");
`endif

endmodule

// File: hdl/extended_euclid_bezout_top.sv
// Extended Euclid block: returns g = |gcd(A,B)| and x, y with A*x + B*y = g, using
// truncating division. A request is taken only while the block is idle; it then
// runs the remainder sequence, each Euclid iteration being one zero test, WIDTH
// steps of a restoring divider that yields one quotient bit per cycle, and one
// coefficient update; a final zero test follows, then the result register is
// loaded once it is free. For 32-bit operands there are at most about 46
// iterations. A finished result waits in its own register, so the next request
// may be accepted before the result is taken.
// Depends on eeb_pkg, eeb_ctrl and eeb_dpath.
module extended_euclid_bezout_top
    import eeb_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [WIDTH-1:0] first_operand,
    input  logic signed [WIDTH-1:0] second_operand,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic        [WIDTH-1:0] divisor_value,
    output logic signed [WIDTH:0]   coef_first,
    output logic signed [WIDTH:0]   coef_second
);

    eeb_cmd_t cmd;
    eeb_sts_t sts;

    eeb_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    eeb_dpath #(
        .WIDTH (WIDTH)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .divisor_value  (divisor_value),
        .coef_first     (coef_first),
        .coef_second    (coef_second)
    );

endmodule
